FILE: rtl/fcca_pkg.sv
package fcca_pkg;

    localparam int ADDR_W     = 10;
    localparam int ENTRY_W    = 32;
    localparam int CNT_W      = 11;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // s_tdata: cluster_addr, entry_value, zero pad
    localparam int S_TDATA_W  = 48;
    // m_tdata: cluster_out, entry_out, free_count, zero pad
    localparam int M_TDATA_W  = 56;

    localparam logic [FUNC_W-1:0] FN_FORMAT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_EXTEND = 3'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RESCAN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FAT_CLUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_DIR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT   = 2'd2;

    localparam logic [ENTRY_W-1:0] EOC_MARK  = 32'hFFFF_FFFF;
    localparam logic [ENTRY_W-1:0] FREE_MARK = 32'h0000_0000;

    typedef enum logic [STATUS_W-1:0] {
        RS_OK    = 2'd0,
        RS_FULL  = 2'd1,
        RS_RANGE = 2'd2
    } status_e;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture an input item
        logic walk;        // write one table entry of the format/clear sweep
        logic walk_zero;   // sweep writes free marks only
        logic fmt_free;    // reload free count for a format
        logic ext_link;    // chain end -> next free
        logic ext_mark;    // next free -> end of chain
        logic scan_start;
        logic scan_run;
        logic rd_capture;
        logic wr_entry;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              addr_ok;
        logic              full;
        logic              walk_last;
        logic              scan_done;
        logic              out_free;
    } stat_t;

endpackage

FILE: rtl/fcca_dp.sv
module fcca_dp #(
    parameter int NUM_CLUSTERS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fcca_pkg::cmd_t                cmd,
    output fcca_pkg::stat_t               stat,
    input  logic [fcca_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [fcca_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fcca_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [fcca_pkg::STATUS_W-1:0]  m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fcca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcca_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcca_pkg::*;

    localparam int AW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
    // wide enough for indices, the cluster count itself and 11-bit values
    localparam int IW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam logic [IW-1:0] NCL      = IW'(NUM_CLUSTERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CLUSTERS - 1);
    localparam int LIM_CAP_I = (NUM_CLUSTERS - 1 < 1023) ? NUM_CLUSTERS - 1 : 1023;
    localparam logic [CNT_W-1:0] LIM_CAP  = CNT_W'(LIM_CAP_I);
    localparam logic [IW-1:0]    FREE_MAX = IW'(2047);

    // table storage
    logic [ENTRY_W-1:0] fat_mem [NUM_CLUSTERS];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic [ENTRY_W-1:0] wdata;

    // configuration
    logic [ADDR_W-1:0] fat_clusters_reg;
    logic [ADDR_W-1:0] root_dir_reg;
    logic [CNT_W-1:0]  scan_limit_reg;

    // allocator state
    logic [ADDR_W-1:0] next_free_reg;
    logic [CNT_W-1:0]  free_left_reg;
    logic              full_reg;

    // current item
    logic [FUNC_W-1:0]  func_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ENTRY_W-1:0] val_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [ADDR_W-1:0]  cl_reg;
    logic               have_cl_reg;

    // sweep and scan
    logic [AW-1:0]    walk_idx_reg;
    logic [CNT_W-1:0] scan_ptr_reg;
    logic [CNT_W-1:0] scan_prev_reg;
    logic             scan_pend_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [ADDR_W-1:0]    out_cl_reg;
    logic [ENTRY_W-1:0]   out_entry_reg;
    logic [CNT_W-1:0]     out_free_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic [IW-1:0]      idx_w;
    logic [IW-1:0]      n_w;
    logic [IW-1:0]      root_w;
    logic [ENTRY_W-1:0] fmt_val;
    logic [IW-1:0]      first_data;
    logic [IW-1:0]      free_diff;
    logic [CNT_W-1:0]   fmt_free_val;
    logic [CNT_W-1:0]   scan_lim;
    logic               addr_ok;
    logic               nf_ok;
    logic               walk_last;
    logic               scan_found;
    logic               scan_more;
    logic               scan_done;
    status_e            res_status;

    assign cfg_ready = 1'b1;

    assign addr_ok   = IW'(addr_reg) < NCL;
    assign nf_ok     = IW'(next_free_reg) < NCL;
    assign walk_last = walk_idx_reg == LAST_IDX;

    // format contents of the entry under the sweep
    always_comb begin
        idx_w  = IW'(walk_idx_reg);
        n_w    = IW'(fat_clusters_reg);
        root_w = IW'(root_dir_reg);
        if (idx_w == '0 || idx_w == n_w || idx_w == root_w) begin
            fmt_val = EOC_MARK;
        end else if (idx_w < n_w) begin
            fmt_val = ENTRY_W'(idx_w) + ENTRY_W'(1);
        end else begin
            fmt_val = FREE_MARK;
        end
    end

    // clusters past the root directory, saturated to the count width
    always_comb begin
        first_data = IW'(root_dir_reg) + IW'(1);
        free_diff  = (first_data >= NCL) ? '0 : NCL - first_data;
        fmt_free_val = (free_diff > FREE_MAX) ? CNT_W'(FREE_MAX) : CNT_W'(free_diff);
    end

    assign scan_lim   = (scan_limit_reg > LIM_CAP) ? LIM_CAP : scan_limit_reg;
    assign scan_found = scan_pend_reg && (rdata_reg == FREE_MARK);
    assign scan_more  = scan_ptr_reg <= scan_lim;
    assign scan_done  = scan_found || (!scan_more && !scan_pend_reg);

    always_comb begin
        we    = 1'b0;
        waddr = walk_idx_reg;
        wdata = fmt_val;
        if (cmd.walk) begin
            we    = 1'b1;
            wdata = cmd.walk_zero ? FREE_MARK : fmt_val;
        end else if (cmd.ext_link) begin
            we    = 1'b1;
            waddr = AW'(addr_reg);
            wdata = ENTRY_W'(next_free_reg);
        end else if (cmd.ext_mark) begin
            we    = nf_ok;
            waddr = AW'(next_free_reg);
            wdata = EOC_MARK;
        end else if (cmd.wr_entry) begin
            we    = 1'b1;
            waddr = AW'(addr_reg);
            wdata = val_reg;
        end
    end

    assign raddr = cmd.scan_run ? AW'(scan_ptr_reg) : AW'(addr_reg);

    always_ff @(posedge aclk) begin
        if (we) begin
            fat_mem[waddr] <= wdata;
        end
        rdata_reg <= fat_mem[raddr];
    end

    always_comb begin
        case (func_reg)
            FN_FORMAT, FN_RESCAN: res_status = full_reg ? RS_FULL : RS_OK;
            FN_EXTEND: begin
                if (!addr_ok) begin
                    res_status = RS_RANGE;
                end else begin
                    res_status = have_cl_reg ? RS_OK : RS_FULL;
                end
            end
            FN_READ, FN_WRITE: res_status = addr_ok ? RS_OK : RS_RANGE;
            default: res_status = RS_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_clusters_reg <= ADDR_W'(8);
            root_dir_reg     <= ADDR_W'(9);
            scan_limit_reg   <= CNT_W'(1024);
            next_free_reg    <= '0;
            free_left_reg    <= '0;
            full_reg         <= 1'b1;
            walk_idx_reg     <= '0;
            scan_pend_reg    <= 1'b0;
            have_cl_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FAT_CLUSTERS: fat_clusters_reg <= cfg_data[ADDR_W-1:0];
                    CFG_ROOT_DIR:     root_dir_reg     <= cfg_data[ADDR_W-1:0];
                    CFG_SCAN_LIMIT:   scan_limit_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.load) begin
                have_cl_reg <= 1'b0;
            end

            if (cmd.walk) begin
                walk_idx_reg <= walk_last ? '0 : walk_idx_reg + AW'(1);
            end

            if (cmd.fmt_free) begin
                free_left_reg <= fmt_free_val;
            end

            if (cmd.ext_link) begin
                have_cl_reg <= 1'b1;
            end

            if (cmd.ext_mark && free_left_reg != '0) begin
                free_left_reg <= free_left_reg - CNT_W'(1);
            end

            // one read issued per cycle, its data compared in the next cycle
            if (cmd.scan_start) begin
                scan_pend_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                if (scan_found) begin
                    next_free_reg <= scan_prev_reg[ADDR_W-1:0];
                    full_reg      <= 1'b0;
                end else if (!scan_more && !scan_pend_reg) begin
                    full_reg      <= 1'b1;
                end else begin
                    scan_pend_reg <= scan_more;
                end
            end

            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tuser;
            addr_reg  <= s_tdata[ADDR_W-1:0];
            val_reg   <= s_tdata[ADDR_W +: ENTRY_W];
            entry_reg <= '0;
        end
        if (cmd.ext_link) begin
            cl_reg <= next_free_reg;
        end
        if (cmd.rd_capture) begin
            entry_reg <= rdata_reg;
        end
        if (cmd.scan_start) begin
            scan_ptr_reg <= CNT_W'(root_dir_reg) + CNT_W'(1);
        end else if (cmd.scan_run && scan_more) begin
            scan_ptr_reg  <= scan_ptr_reg + CNT_W'(1);
            scan_prev_reg <= scan_ptr_reg;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status;
            out_cl_reg     <= have_cl_reg ? cl_reg : next_free_reg;
            out_entry_reg  <= entry_reg;
            out_free_reg   <= free_left_reg;
        end
    end

    assign stat.func      = func_reg;
    assign stat.addr_ok   = addr_ok;
    assign stat.full      = full_reg;
    assign stat.walk_last = walk_last;
    assign stat.scan_done = scan_done;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - ADDR_W - ENTRY_W - CNT_W){1'b0}},
                       out_free_reg, out_entry_reg, out_cl_reg};

endmodule

FILE: rtl/fcca_ctrl.sv
module fcca_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  fcca_pkg::stat_t stat,
    output fcca_pkg::cmd_t  cmd
);
    import fcca_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FORMAT,
        S_EXT_LINK,
        S_EXT_MARK,
        S_SCAN,
        S_READ,
        S_READ_CAP,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.walk      = 1'b1;
                cmd.walk_zero = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.func)
                    FN_FORMAT: state_next = S_FORMAT;
                    FN_EXTEND: begin
                        state_next = (stat.addr_ok && !stat.full) ? S_EXT_LINK : S_DONE;
                    end
                    FN_READ:  state_next = stat.addr_ok ? S_READ : S_DONE;
                    FN_WRITE: state_next = stat.addr_ok ? S_WRITE : S_DONE;
                    FN_RESCAN: begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_FORMAT: begin
                cmd.walk     = 1'b1;
                cmd.fmt_free = 1'b1;
                if (stat.walk_last) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_EXT_LINK: begin
                cmd.ext_link = 1'b1;
                state_next   = S_EXT_MARK;
            end
            S_EXT_MARK: begin
                cmd.ext_mark   = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_READ: state_next = S_READ_CAP;
            S_READ_CAP: begin
                cmd.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_WRITE: begin
                cmd.wr_entry = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;

endmodule

FILE: rtl/fat_cluster_chain_allocator_core.sv
// Channel | Direction | Handshake           | Payload
// s_      | in        | s_tvalid / s_tready | tuser: func; tdata: cluster_addr, entry_value
// m_      | out       | m_tvalid / m_tready | tuser: status; tdata: cluster_out, entry_out,
//         |           |                     |        free_count
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After reset a clearing pass zeroes the table with s_tready low.
// One item is handled at a time; the table has one write and one read port.
// Reads and writes of an entry, and rejected requests, go on to the result; rescan, extend
// and format end in a free scan that walks the entries from root+1, one per cycle, and
// stops at the first free entry or past the scan limit.
// The next item is accepted while a result waits on m_tready; its result then waits, s_tready low.
module fat_cluster_chain_allocator_core #(
    parameter int NUM_CLUSTERS = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [9:0] cluster_addr, [41:10] entry_value, [47:42] zero
    input  logic [fcca_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] func
    input  logic [fcca_pkg::FUNC_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] cluster_out, [41:10] entry_out, [52:42] free_count, [55:53] zero
    output logic [fcca_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [fcca_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fcca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcca_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fcca_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fcca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcca_dp #(
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: verif/tb_fat_cluster_chain_allocator_core.sv
module tb_fat_cluster_chain_allocator_core;
    import fcca_pkg::*;

    localparam int NUM_CL          = 1024;
    localparam int WATCHDOG_CYCLES = 10000;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASE_ITEMS     = 95;

    typedef struct {
        status_e             status;
        logic [ADDR_W-1:0]   cluster;
        logic [ENTRY_W-1:0]  entry;
        logic [CNT_W-1:0]    free_cnt;
    } alloc_answer_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // allocation table mirror
    logic [ENTRY_W-1:0]  fat_mirror [NUM_CL];
    logic [ADDR_W-1:0]   mir_next_free;
    logic [CNT_W-1:0]    mir_free_left;
    logic                mir_full;
    logic [ADDR_W-1:0]   cfg_fat_cl;
    logic [ADDR_W-1:0]   cfg_root;
    logic [CNT_W-1:0]    cfg_limit;
    logic [ADDR_W-1:0]   chain_tail;

    alloc_answer_t alloc_answers_q[$];

    int err_count;
    int answers_seen;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_ticket;

    fat_cluster_chain_allocator_core #(
        .NUM_CLUSTERS (NUM_CL)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void put_entry(input int idx, input logic [ENTRY_W-1:0] val);
        if (idx < NUM_CL) fat_mirror[idx] = val;
    endfunction

    function automatic void scan_for_free();
        int top;
        int i;
        top = int'(cfg_limit);
        if (top > NUM_CL - 1) top = NUM_CL - 1;
        if (top > 1023) top = 1023;
        for (i = int'(cfg_root) + 1; i <= top; i++) begin
            if (fat_mirror[i] == FREE_MARK) begin
                mir_next_free = ADDR_W'(i);
                mir_full      = 1'b0;
                return;
            end
        end
        mir_full = 1'b1;
    endfunction

    function automatic void format_mirror();
        int k;
        int first_data;
        foreach (fat_mirror[j]) fat_mirror[j] = FREE_MARK;
        put_entry(0, EOC_MARK);
        for (k = 1; k < int'(cfg_fat_cl); k++) put_entry(k, ENTRY_W'(k + 1));
        put_entry(int'(cfg_fat_cl), EOC_MARK);
        // root mark last: wins over an overlapping table chain
        put_entry(int'(cfg_root), EOC_MARK);
        first_data = int'(cfg_root) + 1;
        if (first_data >= NUM_CL) mir_free_left = '0;
        else if (NUM_CL - first_data > 2047) mir_free_left = CNT_W'(2047);
        else mir_free_left = CNT_W'(NUM_CL - first_data);
        chain_tail = cfg_root;
        scan_for_free();
    endfunction

    function automatic alloc_answer_t fat_apply(input logic [FUNC_W-1:0] fn,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [ENTRY_W-1:0] val);
        alloc_answer_t a;
        logic [ADDR_W-1:0] taken;
        bit linked;
        bit addr_ok;
        a.status = RS_OK;
        a.entry  = '0;
        taken    = '0;
        linked   = 1'b0;
        addr_ok  = int'(addr) < NUM_CL;
        case (fn)
            FN_FORMAT: begin
                format_mirror();
                if (mir_full) a.status = RS_FULL;
            end
            FN_EXTEND: begin
                if (!addr_ok) begin
                    a.status = RS_RANGE;
                end else if (mir_full) begin
                    a.status = RS_FULL;
                end else begin
                    taken = mir_next_free;
                    fat_mirror[addr] = ENTRY_W'(taken);
                    put_entry(int'(taken), EOC_MARK);
                    if (mir_free_left != 0) mir_free_left = mir_free_left - 1'b1;
                    scan_for_free();
                    chain_tail = taken;
                    linked     = 1'b1;
                end
            end
            FN_READ: begin
                if (!addr_ok) a.status = RS_RANGE;
                else a.entry = fat_mirror[addr];
            end
            FN_WRITE: begin
                if (!addr_ok) a.status = RS_RANGE;
                else fat_mirror[addr] = val;
            end
            FN_RESCAN: begin
                scan_for_free();
                if (mir_full) a.status = RS_FULL;
            end
            default: ;
        endcase
        a.cluster  = linked ? taken : mir_next_free;
        a.free_cnt = mir_free_left;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("mismatch on answer %0d, %s: got %0h, want %0h",
                 answers_seen, what, got, want);
    endtask

    task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] addr,
                                 input logic [ENTRY_W-1:0] val);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = '0;
        s_tdata[ADDR_W-1:0]       = addr;
        s_tdata[ADDR_W +: ENTRY_W] = val;
        do @(posedge aclk); while (!s_tready);
        alloc_answers_q.push_back(fat_apply(fn, addr, val));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (alloc_answers_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FAT_CLUSTERS: cfg_fat_cl = data[ADDR_W-1:0];
            CFG_ROOT_DIR:     cfg_root   = data[ADDR_W-1:0];
            CFG_SCAN_LIMIT:   cfg_limit  = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_layout(input int fat_cl, input int root, input int limit);
        wait_drained();
        write_reg(CFG_FAT_CLUSTERS, CFG_DATA_W'(fat_cl));
        write_reg(CFG_ROOT_DIR, CFG_DATA_W'(root));
        write_reg(CFG_SCAN_LIMIT, CFG_DATA_W'(limit));
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
            default: begin src_idle_pct = 34; sink_stall_pct = 34; end
        endcase
    endtask

    // mostly chain growth and freeing near the root, so scans stay short but busy
    task automatic random_request();
        int sel;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] val;
        sel  = $urandom_range(99);
        addr = ADDR_W'($urandom);
        val  = $urandom;
        if (sel < 40) begin
            if ($urandom_range(9) < 7) addr = chain_tail;
            issue_request(FN_EXTEND, addr, val);
        end else if (sel < 60) begin
            if ($urandom_range(1)) addr = ADDR_W'(cfg_root + $urandom_range(0, 48));
            issue_request(FN_READ, addr, val);
        end else if (sel < 75) begin
            if ($urandom_range(3) != 0) begin
                addr = ADDR_W'(cfg_root + $urandom_range(1, 48));
                if ($urandom_range(2) != 0) val = FREE_MARK;
                else if ($urandom_range(1)) val = EOC_MARK;
            end
            issue_request(FN_WRITE, addr, val);
        end else if (sel < 88) begin
            issue_request(FN_RESCAN, addr, val);
        end else if (sel < 91) begin
            issue_request(FN_FORMAT, addr, val);
        end else begin
            issue_request(FN_RESCAN + FUNC_W'($urandom_range(1, 3)), addr, val);
        end
    endtask

    // table cleared by reset, no format yet: full flag set, everything zero
    task automatic test_reset_state();
        issue_request(FN_READ, ADDR_W'(0), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(1023), EOC_MARK);
        issue_request(FN_RESCAN, ADDR_W'(0), FREE_MARK);
        issue_request(FN_READ, ADDR_W'(1023), FREE_MARK);
    endtask

    task automatic test_default_format();
        issue_request(FN_FORMAT, ADDR_W'(0), FREE_MARK);
        issue_request(FN_READ, ADDR_W'(8), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(9), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(10), FREE_MARK);
        issue_request(FN_WRITE, ADDR_W'(1023), EOC_MARK);
        issue_request(FN_WRITE, ADDR_W'(0), FREE_MARK);
        issue_request(FN_READ, ADDR_W'(1023), FREE_MARK);
        issue_request(FN_RESCAN + FUNC_W'(1), ADDR_W'(5), EOC_MARK);
        issue_request(FN_RESCAN + FUNC_W'(2), ADDR_W'(5), EOC_MARK);
        issue_request(FN_RESCAN + FUNC_W'(3), ADDR_W'(5), EOC_MARK);
    endtask

    // scan window of two entries: fill it, extend on full, free one, rescan
    task automatic test_scan_bounds();
        set_layout(8, 9, 11);
        issue_request(FN_FORMAT, ADDR_W'(0), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(9), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(10), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(11), FREE_MARK);
        issue_request(FN_WRITE, ADDR_W'(10), FREE_MARK);
        issue_request(FN_RESCAN, ADDR_W'(0), FREE_MARK);
        wait_drained();
        write_reg(CFG_SCAN_LIMIT, CFG_DATA_W'(1));
        issue_request(FN_RESCAN, ADDR_W'(0), FREE_MARK);
    endtask

    // one free cluster at the top; free count must not wrap below zero
    task automatic test_free_floor();
        set_layout(1021, 1022, 1024);
        issue_request(FN_FORMAT, ADDR_W'(0), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(1022), FREE_MARK);
        issue_request(FN_WRITE, ADDR_W'(1023), FREE_MARK);
        issue_request(FN_RESCAN, ADDR_W'(0), FREE_MARK);
        issue_request(FN_EXTEND, ADDR_W'(1022), FREE_MARK);
    endtask

    task automatic test_long_holdoff();
        int n;
        wait_drained();
        set_idle_mode(0);
        hold_ticket++;
        for (n = 0; n < 20; n++) random_request();
        wait_drained();
    endtask

    task automatic test_random_layouts();
        int fat_tab   [7] = '{8, 1, 1021, 20, 5, 1021, 0};
        int root_tab  [7] = '{9, 2, 1022, 40, 3, 500, 0};
        int limit_tab [7] = '{1024, 1024, 1024, 300, 1, 1024, 0};
        int p;
        int n;
        fat_tab[6]   = $urandom_range(1, 1021);
        root_tab[6]  = $urandom_range(2, 1022);
        limit_tab[6] = $urandom_range(1, 1024);
        for (p = 0; p < 7; p++) begin
            set_layout(fat_tab[p], root_tab[p], limit_tab[p]);
            set_idle_mode(p % 4);
            issue_request(FN_FORMAT, ADDR_W'($urandom), $urandom);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) wait_drained();
                random_request();
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FN_FORMAT;
        cfg_valid = 1'b0;
        cfg_index = CFG_FAT_CLUSTERS;
        cfg_data  = '0;
        err_count = 0;
        hold_ticket = 0;
        set_idle_mode(0);
        foreach (fat_mirror[j]) fat_mirror[j] = FREE_MARK;
        mir_next_free = '0;
        mir_free_left = '0;
        mir_full      = 1'b1;
        cfg_fat_cl    = ADDR_W'(8);
        cfg_root      = ADDR_W'(9);
        cfg_limit     = CNT_W'(1024);
        chain_tail    = ADDR_W'(9);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_default_format();
        test_scan_bounds();
        test_free_floor();
        test_long_holdoff();
        test_random_layouts();

        wait_drained();
        sink_stall_pct = 0;
        repeat (NUM_CL + 64) @(posedge aclk);
        if (err_count == 0 && alloc_answers_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_ticket) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        alloc_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen++;
            if (alloc_answers_q.size() == 0) begin
                report_mismatch("item with no request pending", 64'(m_tdata), 64'(0));
            end else begin
                want = alloc_answers_q.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[ADDR_W-1:0] !== want.cluster)
                    report_mismatch("cluster_out", 64'(m_tdata[ADDR_W-1:0]),
                                    64'(want.cluster));
                if (m_tdata[ADDR_W +: ENTRY_W] !== want.entry)
                    report_mismatch("entry_out", 64'(m_tdata[ADDR_W +: ENTRY_W]),
                                    64'(want.entry));
                if (m_tdata[ADDR_W + ENTRY_W +: CNT_W] !== want.free_cnt)
                    report_mismatch("free_count", 64'(m_tdata[ADDR_W + ENTRY_W +: CNT_W]),
                                    64'(want.free_cnt));
            end
        end
    end

    initial begin
        answers_seen = 0;
    end

    // ends the run when no channel moves an item for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
